[design/pol_pkg.sv]
// Package for the priority-ordered list: sizes, op and status codes, payload structs.
// Used by pol_cell, pol_select and priority_ordered_list. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int INDEX_W = 6;
    localparam int POS_W   = 7;
    localparam int CMP_W   = CNT_W + INDEX_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Stored word layout: handle low, prio, sort key high.
    typedef struct packed {
        logic [15:0] sort_key;
        logic [7:0]  prio;
        logic [7:0]  handle;
    } entry_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         handle;
        logic [7:0]         prio;
        logic [15:0]        sort_key;
        logic [INDEX_W-1:0] index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [7:0]       out_handle;
        logic [7:0]       out_prio;
        logic [15:0]      out_sort_key;
        logic [POS_W-1:0] count;
    } rsp_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        op_t                op;
        logic               ins_en;
        logic               del_en;
        entry_t             probe;
        logic [INDEX_W-1:0] rd_index;
        logic [CNT_W-1:0]   count;
    } cell_ctl_t;

endpackage

`default_nettype wire

[design/pol_cell.sv]
// One slot of the list: holds an entry, compares it with the probe, shifts with neighbors.
// Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_cell (
    input  wire logic                     clk,
    input  wire pol_pkg::cell_ctl_t       ctl,
    input  wire logic [pol_pkg::IDX_W-1:0] slot,
    input  wire pol_pkg::entry_t          prev_word,
    input  wire pol_pkg::entry_t          next_word,
    input  wire logic                     prev_gt,
    input  wire logic                     prev_hit,
    output pol_pkg::entry_t               word,
    output logic                          gt,
    output logic                          hit,
    output logic                          mark
);

    pol_pkg::entry_t word_reg;
    pol_pkg::entry_t word_next;
    logic            valid;
    logic            match;

    assign valid = (pol_pkg::CNT_W'(slot) < ctl.count);
    // Invalid slots count as larger than any probe, so the boundary lands at count.
    assign gt    = !valid ||
                   ({ctl.probe.prio, ctl.probe.sort_key} < {word_reg.prio, word_reg.sort_key});
    assign match = valid && (word_reg.handle == ctl.probe.handle);
    assign hit   = prev_hit || match;
    assign word  = word_reg;

    always_comb
    begin
        case (ctl.op)
            pol_pkg::OP_INSERT: mark = gt && !prev_gt;
            pol_pkg::OP_REMOVE: mark = match && !prev_hit;
            pol_pkg::OP_READ:   mark = valid &&
                (pol_pkg::CMP_W'(slot) == pol_pkg::CMP_W'(ctl.rd_index));
            default:            mark = 1'b0;
        endcase
    end

    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins_en && gt)
        begin
            word_next = prev_gt ? prev_word : ctl.probe;
        end
        else if (ctl.del_en && hit)
        begin
            word_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

[design/pol_select.sv]
// One-hot mark vector from the cell row to a slot number and the marked entry.
// Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_select (
    input  wire logic [pol_pkg::DEPTH-1:0]            mark,
    input  wire pol_pkg::entry_t [pol_pkg::DEPTH-1:0] words,
    output logic                                      any,
    output logic [pol_pkg::IDX_W-1:0]                 pos,
    output pol_pkg::entry_t                           word
);

    always_comb
    begin
        pos  = '0;
        word = '0;
        for (int i = 0; i < pol_pkg::DEPTH; i++)
        begin
            if (mark[i])
            begin
                pos  = pos | pol_pkg::IDX_W'(i);
                word = word | words[i];
            end
        end
    end

    assign any = |mark;

endmodule

`default_nettype wire

[design/priority_ordered_list.sv]
// Priority-ordered list built as a row of DEPTH compare-and-shift cells.
// Insert, read and no-op: accepted in idle, evaluated in the evaluate state, result registered; one item at a time.
// Remove: a not-found result when the handle is absent, else the matching entries leave the row
// (one matching entry leaves the row per cycle; a last sweep step confirms none remain).
// Reset clears the count and control; cell contents stay unknown until written.
`timescale 1ns / 1ps
`default_nettype none

module priority_ordered_list (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pol_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output pol_pkg::rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_SWEEP = 3'b100
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [pol_pkg::CNT_W-1:0]     count_reg;
    logic [pol_pkg::CNT_W-1:0]     count_next;
    pol_pkg::req_t                 req_reg;
    pol_pkg::rsp_t                 rsp_reg;
    pol_pkg::rsp_t                 rsp_data;
    logic                          rsp_valid_reg;
    logic                          rsp_load;
    logic                          can_emit;
    logic                          full;
    logic                          first_load;
    logic [pol_pkg::IDX_W-1:0]     first_pos_reg;
    pol_pkg::entry_t               first_word_reg;

    pol_pkg::cell_ctl_t                   ctl;
    pol_pkg::entry_t                      probe;
    pol_pkg::entry_t [pol_pkg::DEPTH-1:0] words;
    pol_pkg::entry_t [pol_pkg::DEPTH-1:0] prev_words;
    pol_pkg::entry_t [pol_pkg::DEPTH-1:0] next_words;
    logic [pol_pkg::DEPTH-1:0]            gt_vec;
    logic [pol_pkg::DEPTH-1:0]            hit_vec;
    logic [pol_pkg::DEPTH-1:0]            prev_gt_vec;
    logic [pol_pkg::DEPTH-1:0]            prev_hit_vec;
    logic [pol_pkg::DEPTH-1:0]            mark_vec;
    logic                                 sel_any;
    logic [pol_pkg::IDX_W-1:0]            sel_pos;
    pol_pkg::entry_t                      sel_word;
    logic                                 ins_en;
    logic                                 del_en;

    // ---------------------------------------------------------------
    // Handshake: one item in flight; the result register frees the
    // output side so a waiting result never blocks the next accept.
    // ---------------------------------------------------------------
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign can_emit  = !rsp_valid_reg || rsp_ready;
    assign full      = (count_reg >= pol_pkg::CNT_W'(pol_pkg::DEPTH));

    assign probe.handle   = req_reg.handle;
    assign probe.prio     = req_reg.prio;
    assign probe.sort_key = req_reg.sort_key;

    assign ctl.op       = req_reg.op;
    assign ctl.ins_en   = ins_en;
    assign ctl.del_en   = del_en;
    assign ctl.probe    = probe;
    assign ctl.rd_index = req_reg.index;
    assign ctl.count    = count_reg;

    // ---------------------------------------------------------------
    // Cell row. Insert: every cell past the boundary takes its left
    // neighbor, the boundary cell takes the new entry. Remove: every
    // cell at or past the first match takes its right neighbor.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < pol_pkg::DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign prev_words[g]   = '0;
            assign prev_gt_vec[g]  = 1'b0;
            assign prev_hit_vec[g] = 1'b0;
        end
        else
        begin : g_body
            assign prev_words[g]   = words[g-1];
            assign prev_gt_vec[g]  = gt_vec[g-1];
            assign prev_hit_vec[g] = hit_vec[g-1];
        end

        if (g == pol_pkg::DEPTH - 1)
        begin : g_tail
            assign next_words[g] = words[g];
        end
        else
        begin : g_inner
            assign next_words[g] = words[g+1];
        end

        pol_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .slot      (pol_pkg::IDX_W'(g)),
            .prev_word (prev_words[g]),
            .next_word (next_words[g]),
            .prev_gt   (prev_gt_vec[g]),
            .prev_hit  (prev_hit_vec[g]),
            .word      (words[g]),
            .gt        (gt_vec[g]),
            .hit       (hit_vec[g]),
            .mark      (mark_vec[g])
        );
    end

    pol_select u_select (
        .mark  (mark_vec),
        .words (words),
        .any   (sel_any),
        .pos   (sel_pos),
        .word  (sel_word)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rsp_load   = 1'b0;
        rsp_data   = '0;
        ins_en     = 1'b0;
        del_en     = 1'b0;
        first_load = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                case (req_reg.op)
                    pol_pkg::OP_INSERT:
                    begin
                        if (can_emit)
                        begin
                            rsp_load   = 1'b1;
                            state_next = S_IDLE;
                            if (full)
                            begin
                                rsp_data.status     = pol_pkg::ST_FULL;
                                rsp_data.out_handle = req_reg.handle;
                            end
                            else
                            begin
                                ins_en                = 1'b1;
                                count_next            = count_reg + 1'b1;
                                rsp_data.status       = pol_pkg::ST_OK;
                                rsp_data.position     = pol_pkg::POS_W'(sel_pos);
                                rsp_data.out_handle   = probe.handle;
                                rsp_data.out_prio     = probe.prio;
                                rsp_data.out_sort_key = probe.sort_key;
                            end
                        end
                    end

                    pol_pkg::OP_REMOVE:
                    begin
                        if (sel_any)
                        begin
                            // First match leaves now; its slot and data are kept.
                            del_en     = 1'b1;
                            first_load = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = S_SWEEP;
                        end
                        else if (can_emit)
                        begin
                            rsp_load            = 1'b1;
                            rsp_data.status     = pol_pkg::ST_NOT_FOUND;
                            rsp_data.out_handle = req_reg.handle;
                            state_next          = S_IDLE;
                        end
                    end

                    pol_pkg::OP_READ:
                    begin
                        if (can_emit)
                        begin
                            rsp_load          = 1'b1;
                            rsp_data.position = pol_pkg::POS_W'(req_reg.index);
                            state_next        = S_IDLE;
                            if (sel_any)
                            begin
                                rsp_data.status       = pol_pkg::ST_OK;
                                rsp_data.out_handle   = sel_word.handle;
                                rsp_data.out_prio     = sel_word.prio;
                                rsp_data.out_sort_key = sel_word.sort_key;
                            end
                            else
                            begin
                                rsp_data.status = pol_pkg::ST_RANGE;
                            end
                        end
                    end

                    default:
                    begin
                        if (can_emit)
                        begin
                            rsp_load        = 1'b1;
                            rsp_data.status = pol_pkg::ST_OK;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end

            S_SWEEP:
            begin
                // One more duplicate leaves per cycle until none is left.
                if (sel_any)
                begin
                    del_en     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else if (can_emit)
                begin
                    rsp_load              = 1'b1;
                    rsp_data.status       = pol_pkg::ST_OK;
                    rsp_data.position     = pol_pkg::POS_W'(first_pos_reg);
                    rsp_data.out_handle   = first_word_reg.handle;
                    rsp_data.out_prio     = first_word_reg.prio;
                    rsp_data.out_sort_key = first_word_reg.sort_key;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_data.count = pol_pkg::POS_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_data;
        end
        if (first_load)
        begin
            first_pos_reg  <= sel_pos;
            first_word_reg <= sel_word;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pol_pkg::CNT_W'(pol_pkg::DEPTH))
        else $error("entry count above depth");

    a_sweep_is_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (req_reg.op == pol_pkg::OP_REMOVE))
        else $error("sweep entered for an op other than remove");

    a_sweep_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |=> (count_reg <= $past(count_reg)))
        else $error("count grew during remove sweep");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && req_reg.op == pol_pkg::OP_INSERT && can_emit && !full)
        |=> (count_reg == pol_pkg::CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted insert did not add one entry");

endmodule

`default_nettype wire

[bench/priority_ordered_list_tb.sv]
// Self-checking bench for priority_ordered_list: directed list cases, then random episodes.
// Depends on pol_pkg (req_t, rsp_t, entry_t, op and status codes) and the design top level.
`timescale 1ns / 1ps

module priority_ordered_list_tb;

    import pol_pkg::*;

    // The idle limit sits well above the slowest remove plus the longest drawn gap and stall.
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int TARGET_ITEMS = 800;

    typedef enum int {
        EP_GROW,
        EP_SHRINK,
        EP_MIXED,
        EP_NOISE
    } episode_t;

    // One pending request, with a flag that holds it back until all results are in.
    typedef struct {
        req_t r;
        bit   drain;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    priority_ordered_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the list: sorted entries and the number held.
    // ------------------------------------------------------------------
    entry_t shadow_list[DEPTH];
    int     shadow_len = 0;

    stim_t  req_backlog[$];   // requests not yet driven
    rsp_t   rsp_due[$];       // predicted results, oldest first
    int     req_taken = 0;    // request transfers so far
    int     rsp_matched = 0;  // result transfers matched to a prediction
    int     err_cnt = 0;
    bit     tx_quiet = 1'b0;  // sender runs back to back while set
    bit     rx_quiet = 1'b0;  // receiver never stalls while set

    // Apply one request to the shadow list and return the result it must give.
    function automatic rsp_t list_apply(req_t r);
        rsp_t   o;
        int     pos;
        int     w;
        bit     found;
        entry_t hit;
        o = '0;
        o.status = ST_OK;
        case (r.op)
            OP_INSERT:
            begin
                if (shadow_len >= DEPTH)
                begin
                    o.status = ST_FULL;
                    o.out_handle = r.handle;
                end
                else
                begin
                    // Ties on both keys go behind the stored entry: arrival order kept.
                    pos = shadow_len;
                    found = 1'b0;
                    for (int i = 0; i < shadow_len; i++)
                    begin
                        if (!found && (r.prio < shadow_list[i].prio ||
                            (r.prio == shadow_list[i].prio &&
                             r.sort_key < shadow_list[i].sort_key)))
                        begin
                            pos = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos].handle = r.handle;
                    shadow_list[pos].prio = r.prio;
                    shadow_list[pos].sort_key = r.sort_key;
                    shadow_len++;
                    o.position = POS_W'(pos);
                    o.out_handle = r.handle;
                    o.out_prio = r.prio;
                    o.out_sort_key = r.sort_key;
                end
            end
            OP_REMOVE:
            begin
                // Every entry with the handle goes; the first one is reported.
                w = 0;
                pos = 0;
                found = 1'b0;
                hit = '0;
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (shadow_list[i].handle == r.handle)
                    begin
                        if (!found)
                        begin
                            found = 1'b1;
                            pos = i;
                            hit = shadow_list[i];
                        end
                    end
                    else
                    begin
                        shadow_list[w] = shadow_list[i];
                        w++;
                    end
                end
                if (!found)
                begin
                    o.status = ST_NOT_FOUND;
                    o.out_handle = r.handle;
                end
                else
                begin
                    shadow_len = w;
                    o.position = POS_W'(pos);
                    o.out_handle = hit.handle;
                    o.out_prio = hit.prio;
                    o.out_sort_key = hit.sort_key;
                end
            end
            OP_READ:
            begin
                o.position = POS_W'(r.index);
                if (r.index >= shadow_len)
                    o.status = ST_RANGE;
                else
                begin
                    o.out_handle = shadow_list[r.index].handle;
                    o.out_prio = shadow_list[r.index].prio;
                    o.out_sort_key = shadow_list[r.index].sort_key;
                end
            end
            default:
            begin
                // Unused code: no change, all data fields zero.
            end
        endcase
        o.count = POS_W'(shadow_len);
        return o;
    endfunction

    task automatic queue_req(op_t op, int h, int p, int k, int idx, bit drain);
        stim_t s;
        s.r.op = op;
        s.r.handle = 8'(h);
        s.r.prio = 8'(p);
        s.r.sort_key = 16'(k);
        s.r.index = INDEX_W'(idx);
        s.drain = drain;
        req_backlog.insert(req_backlog.size(), s);
    endtask

    // Random run of requests with a given mix. Handles mostly come from a small
    // pool so that removes find entries, often several with one handle.
    task automatic queue_episode(episode_t kind, int len);
        int   pick;
        op_t  op;
        int   h;
        int   p;
        int   k;
        int   idx;
        for (int n = 0; n < len; n++)
        begin
            pick = $urandom_range(0, 99);
            case (kind)
                EP_GROW:   op = pick < 80 ? OP_INSERT : pick < 90 ? OP_READ :
                                pick < 98 ? OP_REMOVE : OP_NOP;
                EP_SHRINK: op = pick < 55 ? OP_REMOVE : pick < 80 ? OP_READ :
                                pick < 95 ? OP_INSERT : OP_NOP;
                EP_MIXED:  op = pick < 40 ? OP_INSERT : pick < 65 ? OP_REMOVE :
                                pick < 95 ? OP_READ : OP_NOP;
                default:   op = op_t'($urandom_range(0, 3));
            endcase
            if (kind == EP_NOISE)
            begin
                h = $urandom_range(0, 255);
                p = $urandom_range(0, 255);
                k = $urandom_range(0, 65535);
                idx = $urandom_range(0, 63);
            end
            else
            begin
                h = $urandom_range(0, 99) < 85 ? $urandom_range(0, 15) : $urandom_range(0, 255);
                // Narrow key ranges give plenty of ties on one or both keys.
                p = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
                k = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
                idx = $urandom_range(0, 99) < 60 ? $urandom_range(0, 15) :
                      $urandom_range(0, 63);
            end
            queue_req(op, h, p, k, idx, n == 0 && $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. A request is predicted on the edge of its transfer.
    // After each transfer a random idle gap is drawn; a request
    // marked for draining waits until every result has been taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int    gap_now;
        int    taken_now;
        stim_t s;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_now = 0;
        end
        else
        begin
            taken_now = req_taken;
            if (req_valid && req_ready)
            begin
                rsp_due.insert(rsp_due.size(), list_apply(req));
                taken_now++;
                req_taken <= taken_now;
                if ($urandom_range(0, 29) == 0)
                    tx_quiet = ~tx_quiet;
                gap_now = tx_quiet ? 0 : $urandom_range(0, 13);
            end
            else if (!req_valid && gap_now > 0)
                gap_now--;

            if (req_valid && !req_ready)
            begin
                // Payload and valid held until the transfer.
            end
            else if (gap_now > 0)
                req_valid <= 1'b0;
            else if (req_backlog.size() != 0 &&
                     (!req_backlog[0].drain || taken_now == rsp_matched))
            begin
                s = req_backlog.pop_front();
                req <= s.r;
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each result transfer is compared with the oldest
    // prediction; ready then drops for a randomly drawn stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int   stall_now;
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_now = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    err_cnt++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("position", 32'(want.position), 32'(rsp.position));
                    check_field("out_handle", 32'(want.out_handle), 32'(rsp.out_handle));
                    check_field("out_prio", 32'(want.out_prio), 32'(rsp.out_prio));
                    check_field("out_sort_key", 32'(want.out_sort_key),
                                32'(rsp.out_sort_key));
                    check_field("count", 32'(want.count), 32'(rsp.count));
                    rsp_matched <= rsp_matched + 1;
                end
                if ($urandom_range(0, 29) == 0)
                    rx_quiet = ~rx_quiet;
                stall_now = rx_quiet ? 0 : $urandom_range(0, 13);
            end
            else if (stall_now > 0)
                stall_now--;
            rsp_ready <= (stall_now == 0);
        end
    end

    // Watchdog: too long without any transfer on either channel.
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("priority_ordered_list_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        // Empty list: read out of range, remove of a missing handle, unused code.
        queue_req(OP_READ, 0, 0, 0, 0, 1'b0);
        queue_req(OP_REMOVE, 8'hA5, 0, 0, 0, 1'b0);
        queue_req(OP_NOP, 8'hFF, 8'hFF, 16'hFFFF, 63, 1'b0);
        // Key extremes, then ties: equal keys keep arrival order.
        queue_req(OP_INSERT, 255, 255, 65535, 0, 1'b0);
        queue_req(OP_INSERT, 0, 0, 0, 0, 1'b0);
        queue_req(OP_INSERT, 1, 8, 100, 0, 1'b0);
        queue_req(OP_INSERT, 2, 8, 100, 0, 1'b0);
        queue_req(OP_INSERT, 3, 8, 99, 0, 1'b0);
        queue_req(OP_INSERT, 4, 8, 101, 0, 1'b0);
        queue_req(OP_INSERT, 5, 255, 65535, 0, 1'b0);
        // Duplicate handle is stored again.
        queue_req(OP_INSERT, 1, 200, 7, 0, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 3, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 7, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 8, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 63, 1'b0);
        // Remove both copies of handle 1; the first one is reported.
        queue_req(OP_REMOVE, 1, 0, 0, 0, 1'b1);
        queue_req(OP_REMOVE, 1, 0, 0, 0, 1'b0);
        queue_req(OP_REMOVE, 77, 0, 0, 0, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 0, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 5, 1'b0);
        queue_req(OP_NOP, 0, 0, 0, 0, 1'b0);

        // Fill well past DEPTH so inserts into a full list are refused.
        for (int n = 0; n < DEPTH + 8; n++)
            queue_req(OP_INSERT, $urandom_range(0, 15), $urandom_range(0, 7),
                      $urandom_range(0, 3), 0, 1'b0);
        queue_req(OP_READ, 0, 0, 0, 63, 1'b1);

        while (req_backlog.size() < TARGET_ITEMS)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            queue_episode(pick < 35 ? EP_GROW : pick < 60 ? EP_SHRINK :
                          pick < 90 ? EP_MIXED : EP_NOISE, $urandom_range(20, 90));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid || rsp_matched != req_taken)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (rsp_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", rsp_due.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("priority_ordered_list_tb: done, clean");
        else
            $display("priority_ordered_list_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/pol_pkg.sv
design/pol_cell.sv
design/pol_select.sv
design/priority_ordered_list.sv
bench/priority_ordered_list_tb.sv
